// File: src/mdsv_pkg.sv
// Shared types, constants and table builders for the decaying sine voice.
package mdsv_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 28;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_RECIPROCAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR    = 2'd2;

    localparam logic [4:0]  CHAN_RESET  = 5'd1;
    localparam logic [27:0] RATE_RESET  = 28'd22906492;
    localparam logic [15:0] DECAY_RESET = 16'd65529;

    // MIDI decoding
    localparam logic [7:0] STATUS_MASK = 8'hf0;
    localparam logic [7:0] NOTE_ON     = 8'h90;
    localparam logic [7:0] CHAN_MASK   = 8'h0f;

    // Amplitude is Q0.16; a retrigger restarts it at one half
    localparam logic [15:0] AMP_HALF = 16'h8000;

    // Shared multiplier: 16-bit by 28-bit unsigned
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 28;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef logic [1:0] t_mul_sel;
    localparam t_mul_sel MUL_FREQ_LO = 2'd0;
    localparam t_mul_sel MUL_FREQ_HI = 2'd1;
    localparam t_mul_sel MUL_DECAY   = 2'd2;
    localparam t_mul_sel MUL_SINE    = 2'd3;

    // Note frequency, Q14.16 Hz
    localparam int FREQ_W     = 30;
    localparam int NOTE_COUNT = 128;
    localparam int NOTE_W     = 7;

    // Top octave (notes 120..131), round(f * 2^16)
    localparam logic [FREQ_W-1:0] NOTE_BASE [12] = '{
        30'd548668578, 30'd581294109, 30'd615859655, 30'd652480568,
        30'd691279090, 30'd732384684, 30'd775934543, 30'd822074013,
        30'd870957077, 30'd922746880, 30'd977616265, 30'd1035748353
    };

    typedef logic [FREQ_W-1:0] t_note_tab [NOTE_COUNT];

    function automatic logic [FREQ_W-1:0] note_freq_q16(input int unsigned n);
        int unsigned     sh;
        longint unsigned base;
        sh   = 10 - n / 12;
        base = 64'(NOTE_BASE[n % 12]);
        if (sh == 0) begin
            return FREQ_W'(base);
        end
        return FREQ_W'((base + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic t_note_tab build_note_tab();
        t_note_tab tab;
        for (int n = 0; n < NOTE_COUNT; n++) begin
            tab[n] = note_freq_q16(n);
        end
        return tab;
    endfunction

    localparam t_note_tab NOTE_FREQ_TAB = build_note_tab();

    // Sine series constants, Q30
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Controller <-> datapath
    typedef struct packed {
        logic     capture;     // item accepted: latch note frequency
        t_mul_sel mul_sel;
        logic     acc_lo;      // hold low partial product
        logic     inc_ld;      // new increment, arm retrigger
        logic     phase_step;
        logic     amp_step;
        logic     rom_rd;
        logic     out_ld;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic hit;             // note-on on our channel
    } t_sts;

endpackage

// File: src/mdsv_in_if.sv
// Input item channel: MIDI events and sample ticks.
interface mdsv_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] status_byte;
    logic [6:0] note_number;

    modport source (output valid, action, status_byte, note_number, input ready);
    modport sink   (input valid, action, status_byte, note_number, output ready);
endinterface

// File: src/mdsv_out_if.sv
// Output item channel: audio samples.
interface mdsv_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

// File: src/mdsv_sine_rom.sv
// Quarter-wave sine table with quadrant folding and registered read.
module mdsv_sine_rom
    import mdsv_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rd,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] i_idx,
    output logic [SAMPLE_BITS-2:0]              o_mag,
    output logic                                o_neg
);
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int QB    = IDX_W - 2;
    localparam int QD    = SINE_TABLE_DEPTH / 4;
    localparam int MAG_W = SAMPLE_BITS - 1;

    // entries 0..QD of the first quadrant; entry QD is the peak
    typedef logic [MAG_W-1:0] t_quarter [QD+1];

    function automatic t_quarter build_quarter();
        t_quarter        tab;
        longint unsigned t, u, u2, h, s, mag, full;
        full = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        for (int j = 0; j <= QD; j++) begin
            t  = 64'(j) << (30 - QB);
            u  = (t * HALF_PI_Q30) >> 30;
            u2 = (u * u) >> 30;
            h  = Q30_ONE - u2 / 72;
            h  = Q30_ONE - ((u2 * h) >> 30) / 42;
            h  = Q30_ONE - ((u2 * h) >> 30) / 20;
            h  = Q30_ONE - ((u2 * h) >> 30) / 6;
            s  = (u * h) >> 30;
            if (s > Q30_ONE) begin
                s = Q30_ONE;
            end
            mag    = (s * full + (64'd1 << 29)) >> 30;
            tab[j] = MAG_W'(mag);
        end
        return tab;
    endfunction

    localparam t_quarter SINE_QUARTER = build_quarter();

    logic [1:0]    quad;
    logic [QB-1:0] pos_in;
    logic [QB:0]   pos;

    assign quad   = i_idx[IDX_W-1 -: 2];
    assign pos_in = i_idx[QB-1:0];
    // odd quadrants run the table backwards
    assign pos    = quad[0] ? ((QB+1)'(QD) - {1'b0, pos_in}) : {1'b0, pos_in};

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            o_mag <= SINE_QUARTER[pos];
            o_neg <= quad[1];
        end
    end

endmodule

// File: src/mdsv_ctrl.sv
// Sequencer for events and ticks; owns the output valid flag.
module mdsv_ctrl
    import mdsv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EV_LO  = 3'd1;
    localparam logic [2:0] S_EV_HI  = 3'd2;
    localparam logic [2:0] S_EV_SUM = 3'd3;
    localparam logic [2:0] S_TK_AMP = 3'd4;
    localparam logic [2:0] S_TK_ROM = 3'd5;
    localparam logic [2:0] S_TK_MUL = 3'd6;
    localparam logic [2:0] S_TK_OUT = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       slot_free;

    // no item is taken while reset is held
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = o_in_ready && i_in_valid;
    assign slot_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_SINE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = accept;
                if (accept) begin
                    if (i_sts.is_tick) begin
                        n_state = S_TK_AMP;
                    end else if (i_sts.hit) begin
                        n_state = S_EV_LO;
                    end
                end
            end
            S_EV_LO: begin
                o_cmd.mul_sel = MUL_FREQ_LO;
                n_state       = S_EV_HI;
            end
            S_EV_HI: begin
                o_cmd.mul_sel = MUL_FREQ_HI;
                o_cmd.acc_lo  = 1'b1;
                n_state       = S_EV_SUM;
            end
            S_EV_SUM: begin
                o_cmd.inc_ld = 1'b1;
                n_state      = S_IDLE;
            end
            S_TK_AMP: begin
                o_cmd.mul_sel    = MUL_DECAY;
                o_cmd.phase_step = 1'b1;
                n_state          = S_TK_ROM;
            end
            S_TK_ROM: begin
                o_cmd.amp_step = 1'b1;
                o_cmd.rom_rd   = 1'b1;
                n_state        = S_TK_MUL;
            end
            S_TK_MUL: begin
                n_state = S_TK_OUT;
            end
            S_TK_OUT: begin
                // product stays put while the output slot is busy
                if (slot_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_OUT) && r_out_valid && !i_out_ready |=> (r_state == S_TK_OUT))
        else $error("result loaded over a waiting item");

    a_miss_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_sts.is_tick && !i_sts.hit |=> (r_state == S_IDLE))
        else $error("ignored event started work");

    a_tick_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_MUL) |-> ##1 (r_state == S_TK_OUT) && $past(o_cmd.rom_rd, 2))
        else $error("sine read not issued before multiply");

endmodule

// File: src/mdsv_dp.sv
// Datapath: config registers, voice state, shared multiplier, sine table.
module mdsv_dp
    import mdsv_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 24,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_action,
    input  logic [7:0]                    i_status_byte,
    input  logic [NOTE_W-1:0]             i_note_number,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int MAG_W = SAMPLE_BITS - 1;
    localparam int SUM_W = PROD_W + 16;
    localparam int INC_SHIFT = 56 - PHASE_BITS;

    localparam longint unsigned RESET_FREQ_Q16 = 64'd220 << 16;
    localparam longint unsigned RESET_PROD     = RESET_FREQ_Q16 * 64'(RATE_RESET);
    localparam logic [PHASE_BITS-1:0] INC_MAX  = '1;
    localparam logic [PHASE_BITS-1:0] RESET_INC =
        ((RESET_PROD >> INC_SHIFT) > 64'(INC_MAX)) ? INC_MAX
                                                   : PHASE_BITS'(RESET_PROD >> INC_SHIFT);
    localparam logic [PHASE_BITS:0] PHASE_ONE = {1'b1, {PHASE_BITS{1'b0}}};

    logic [4:0]                r_midi_ch;
    logic [27:0]               r_rate;
    logic [15:0]               r_decay;
    logic [FREQ_W-1:0]         r_freq;
    logic [PROD_W-1:0]         r_prod;
    logic [PROD_W-1:0]         r_acc;
    logic [PHASE_BITS-1:0]     r_inc;
    logic [PHASE_BITS:0]       r_phase;
    logic [15:0]               r_amp;
    logic                      r_retrig;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [SUM_W-1:0]    inc_sum;
    logic [PHASE_BITS-1:0] inc_new;
    logic [PHASE_BITS:0] phase_sum;
    logic [IDX_W-1:0]    rom_idx;
    logic [MAG_W-1:0]    rom_mag;
    logic                rom_neg;
    logic [PROD_W-1:0]   rounded;
    logic [SAMPLE_BITS-1:0] mag_ext;

    // note-on on the configured channel; channel 0 and above 16 never match
    assign o_sts.is_tick = i_action;
    assign o_sts.hit     = ((i_status_byte & STATUS_MASK) == NOTE_ON) && (r_midi_ch != 5'd0)
                        && ({1'b0, 4'(i_status_byte & CHAN_MASK)} == r_midi_ch - 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midi_ch <= CHAN_RESET;
            r_rate    <= RATE_RESET;
            r_decay   <= DECAY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIDI_CHANNEL:    r_midi_ch <= i_cfg_data[4:0];
                CFG_RATE_RECIPROCAL: r_rate    <= i_cfg_data[27:0];
                CFG_DECAY_FACTOR:    r_decay   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_FREQ_LO: begin
                mul_a = r_freq[15:0];
                mul_b = r_rate;
            end
            MUL_FREQ_HI: begin
                mul_a = MUL_A_W'(r_freq[FREQ_W-1:16]);
                mul_b = r_rate;
            end
            MUL_DECAY: begin
                mul_a = r_amp;
                mul_b = MUL_B_W'(r_decay);
            end
            default: begin
                mul_a = r_amp;
                mul_b = MUL_B_W'(rom_mag);
            end
        endcase
    end

    // increment = (freq * rate) >> (56 - PHASE_BITS), saturating at all ones
    assign inc_sum   = (SUM_W'(r_prod) << 16) + SUM_W'(r_acc);
    assign inc_new   = (|inc_sum[SUM_W-1:56]) ? INC_MAX : inc_sum[55 -: PHASE_BITS];
    assign phase_sum = r_phase + {1'b0, r_inc};
    // a phase of exactly one reads index zero
    assign rom_idx   = r_phase[PHASE_BITS] ? '0 : r_phase[PHASE_BITS-1 -: IDX_W];
    assign rounded   = r_prod + PROD_W'(16'h8000);
    assign mag_ext   = {1'b0, rounded[16 +: MAG_W]};

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (i_cmd.capture) begin
            r_freq <= NOTE_FREQ_TAB[i_note_number];
        end
        if (i_cmd.acc_lo) begin
            r_acc <= r_prod;
        end
        if (i_cmd.out_ld) begin
            r_sample <= rom_neg ? -$signed(mag_ext) : $signed(mag_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc    <= RESET_INC;
            r_phase  <= '0;
            r_amp    <= '0;
            r_retrig <= 1'b0;
        end else begin
            if (i_cmd.inc_ld) begin
                r_inc    <= inc_new;
                r_retrig <= 1'b1;
            end else if (i_cmd.amp_step) begin
                r_retrig <= 1'b0;
            end
            if (i_cmd.amp_step) begin
                r_amp <= r_retrig ? AMP_HALF : r_prod[31:16];
            end
            if (i_cmd.phase_step) begin
                r_phase <= (phase_sum > PHASE_ONE) ? '0 : phase_sum;
            end
        end
    end

    mdsv_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_sine_rom (
        .i_clk (i_clk),
        .i_rd  (i_cmd.rom_rd),
        .i_idx (rom_idx),
        .o_mag (rom_mag),
        .o_neg (rom_neg)
    );

    assign o_sample = r_sample;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHASE_ONE)
        else $error("phase beyond one");

    a_amp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_amp <= AMP_HALF)
        else $error("amplitude above one half");

    a_retrigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.amp_step && r_retrig |=> (r_amp == AMP_HALF) && !r_retrig)
        else $error("retrigger not applied");

endmodule

// File: src/midi_decaying_sine_voice.sv
// Top level of the MIDI-driven decaying sine voice.
// Items arrive in time order on i_evt: MIDI events (action 0) and sample ticks
// (action 1). A note-on on the configured channel loads a new phase increment
// and restarts the amplitude at one half on the next tick; other events are
// dropped. Each tick decays the amplitude, steps the phase and returns one
// sample on o_smp. One 16x28 multiplier is shared by every product, so an
// ignored event needs no further step, a note-on takes two partial products
// for the increment plus the add, and a tick the decay product, sine table
// read, sample product and load, the load waiting while the output stalls. A
// finished sample waits in the output register while the next item is taken.
// Configuration writes take effect at once; a new rate_reciprocal applies from
// the next note-on.
module midi_decaying_sine_voice
    import mdsv_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 24,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mdsv_in_if.sink               i_evt,
    mdsv_out_if.source            o_smp
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;
    logic signed [SAMPLE_BITS-1:0] sample;

    mdsv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_smp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mdsv_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_evt.action),
        .i_status_byte (i_evt.status_byte),
        .i_note_number (i_evt.note_number),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_sample      (sample)
    );

    assign i_evt.ready  = in_ready;
    assign o_smp.valid  = out_valid;
    assign o_smp.sample = sample;

endmodule
